// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// ===== rtl/pbts_pkg.sv =====
// Types, constants and helpers shared by the transfer splitter modules.
package pbts_pkg;

    // Page size and longest accepted request, in bytes.
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_LENGTH  = 65536;
    localparam int PAGE_BITS   = $clog2(PAGE_BYTES);
    localparam int SPAN_W      = PAGE_BITS + 1;

    // Field widths of the request and chunk items.
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 17;
    localparam int CHUNK_LEN_W = 13;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [SPAN_W-1:0]      t_span;
    typedef logic [CHUNK_LEN_W-1:0] t_clen;
    typedef logic [QPTR_W-1:0]      t_qptr;
    typedef logic [QCNT_W-1:0]      t_qcnt;

    // One transfer request item.
    typedef struct packed {
        t_addr local_addr;
        t_addr remote_addr;
        t_len  length;
        logic  direction;
    } t_req;

    // One chunk command item.
    typedef struct packed {
        t_addr chunk_local_addr;
        t_addr chunk_remote_addr;
        t_clen chunk_len;
        logic  chunk_dir;
        logic  last_chunk;
        logic  too_long;
    } t_chunk;

    // Class that the front gives each request it queues.
    typedef enum logic {
        KIND_SPLIT,
        KIND_TOO_LONG
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_req  req;
    } t_cmd;

    // Head of the command queue as the back sees it.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    // Sequencer states of the back.
    typedef enum logic {
        BACK_IDLE,
        BACK_SPLIT
    } t_back_state;

    // Bytes from an address up to the end of its page.
    function automatic t_span page_room(input t_addr addr);
        return t_span'(PAGE_BYTES) - t_span'(addr[PAGE_BITS-1:0]);
    endfunction

endpackage

// ===== rtl/pbts_front.sv =====
// Front of the splitter: accepts requests, classifies them and queues commands.
module pbts_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  pbts_pkg::t_req        i_req,
    output pbts_pkg::t_cmd_head   o_head,
    input  logic                  i_take
);

    pbts_pkg::t_cmd  r_mem [pbts_pkg::QUEUE_DEPTH];
    pbts_pkg::t_qptr r_wr_ptr;
    pbts_pkg::t_qptr r_rd_ptr;
    pbts_pkg::t_qcnt r_count;
    pbts_pkg::t_qptr n_wr_ptr;
    pbts_pkg::t_qptr n_rd_ptr;
    pbts_pkg::t_qcnt n_count;
    pbts_pkg::t_cmd  w_cmd;
    logic            w_accept;
    logic            w_enq;
    logic            w_deq;

    // A zero-length request is accepted and dropped; others are queued.
    always_comb begin
        w_cmd.req  = i_req;
        w_cmd.kind = (i_req.length > pbts_pkg::t_len'(pbts_pkg::MAX_LENGTH)) ?
                     pbts_pkg::KIND_TOO_LONG : pbts_pkg::KIND_SPLIT;
        w_accept   = i_push && !o_full;
        w_enq      = w_accept && (i_req.length != '0);
        w_deq      = i_take && o_head.valid;
    end

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_enq) begin
            n_wr_ptr = (r_wr_ptr == pbts_pkg::t_qptr'(pbts_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (w_deq) begin
            n_rd_ptr = (r_rd_ptr == pbts_pkg::t_qptr'(pbts_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (w_enq && !w_deq) begin
            n_count = r_count + 1'b1;
        end else if (w_deq && !w_enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_full       = (r_count == pbts_pkg::t_qcnt'(pbts_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

endmodule

// ===== rtl/pbts_back.sv =====
// Back of the splitter: walks one command and emits its chunks into an output register.
module pbts_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pbts_pkg::t_cmd_head   i_head,
    output logic                  o_take,
    output logic                  o_empty,
    input  logic                  i_pop,
    output pbts_pkg::t_chunk      o_chunk
);

    pbts_pkg::t_back_state r_state;
    pbts_pkg::t_back_state n_state;
    pbts_pkg::t_addr       r_la;
    pbts_pkg::t_addr       r_ra;
    pbts_pkg::t_len        r_left;
    logic                  r_dir;
    logic                  r_err;
    logic                  r_out_valid;
    logic                  n_out_valid;
    pbts_pkg::t_chunk      r_out;
    pbts_pkg::t_span       w_lroom;
    pbts_pkg::t_span       w_rroom;
    pbts_pkg::t_span       w_room;
    pbts_pkg::t_span       w_span;
    logic                  w_fits;
    logic                  w_last;
    logic                  w_slot_free;
    logic                  w_out_load;
    pbts_pkg::t_chunk      w_chunk;

    // Next chunk: the shortest of the local room, the remote room and what is left.
    always_comb begin
        w_lroom = pbts_pkg::page_room(r_la);
        w_rroom = pbts_pkg::page_room(r_ra);
        w_room  = (w_lroom < w_rroom) ? w_lroom : w_rroom;
        w_fits  = (pbts_pkg::t_len'(w_room) >= r_left);
        w_span  = w_fits ? pbts_pkg::t_span'(r_left) : w_room;
        w_last  = r_err || w_fits;

        w_chunk.chunk_local_addr  = r_la;
        w_chunk.chunk_remote_addr = r_ra;
        w_chunk.chunk_len         = r_err ? '0 : pbts_pkg::t_clen'(w_span);
        w_chunk.chunk_dir         = r_dir;
        w_chunk.last_chunk        = w_last;
        w_chunk.too_long          = r_err;
    end

    assign w_slot_free = !r_out_valid || i_pop;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pbts_pkg::BACK_IDLE: begin
                if (i_head.valid) begin
                    n_state = pbts_pkg::BACK_SPLIT;
                end
            end
            pbts_pkg::BACK_SPLIT: begin
                if (w_slot_free && w_last) begin
                    n_state = pbts_pkg::BACK_IDLE;
                end
            end
            default: begin
                n_state = pbts_pkg::BACK_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_take     = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            pbts_pkg::BACK_IDLE: begin
                o_take = i_head.valid;
            end
            pbts_pkg::BACK_SPLIT: begin
                w_out_load = w_slot_free;
            end
            default: begin
                o_take     = 1'b0;
                w_out_load = 1'b0;
            end
        endcase
    end

    assign n_out_valid = w_out_load || (r_out_valid && !i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pbts_pkg::BACK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working request: loaded from the queue head, advanced by each chunk.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_la   <= i_head.cmd.req.local_addr;
            r_ra   <= i_head.cmd.req.remote_addr;
            r_left <= i_head.cmd.req.length;
            r_dir  <= i_head.cmd.req.direction;
            r_err  <= (i_head.cmd.kind == pbts_pkg::KIND_TOO_LONG);
        end else if (w_out_load) begin
            r_la   <= r_la + pbts_pkg::t_addr'(w_span);
            r_ra   <= r_ra + pbts_pkg::t_addr'(w_span);
            r_left <= r_left - pbts_pkg::t_len'(w_span);
        end
    end

    // Output register holding the oldest waiting chunk.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_chunk;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_chunk = r_out;

endmodule

// ===== rtl/page_boundary_transfer_splitter_top.sv =====
// Top level of the page boundary transfer splitter.
//
//  Channel   Handshake          Payload            Dir
//  request   i_push / o_full    i_req   (t_req)    in
//  chunk     o_empty / i_pop    o_chunk (t_chunk)  out
//
// A request is written straight into a two-entry command queue in the front.
// The back loads a command in its idle state, then emits one chunk per cycle
// while its output register is empty or being popped.
// Reset is synchronous and active low; it empties the queue and the output register.
// While pop stays low the back stalls on its full output register, the queue then
// fills and full rises; zero-length requests are accepted and produce no chunk.
module page_boundary_transfer_splitter_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  pbts_pkg::t_req    i_req,
    output logic              o_empty,
    input  logic              i_pop,
    output pbts_pkg::t_chunk  o_chunk
);

    pbts_pkg::t_cmd_head w_head;
    logic                w_take;

    // Request intake and classification.
    pbts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_req   (i_req),
        .o_head  (w_head),
        .i_take  (w_take)
    );

    // Chunk sequencer and output register.
    pbts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_take  (w_take),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_chunk (o_chunk)
    );

endmodule

// ===== rtl/pbts_checker.sv =====
// Port-level checks of the splitter and the bind that attaches them.
`include "assert_macros.svh"

module pbts_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_empty,
    input  logic              i_pop,
    input  pbts_pkg::t_chunk  o_chunk
);

    pbts_pkg::t_len w_local_end;
    pbts_pkg::t_len w_remote_end;
    logic           w_in_page;
    logic           w_reject_ok;
    logic           w_chunk_ok;

    // End offsets of the shown chunk inside its local and remote pages.
    assign w_local_end  = pbts_pkg::t_len'(o_chunk.chunk_local_addr[pbts_pkg::PAGE_BITS-1:0])
                        + pbts_pkg::t_len'(o_chunk.chunk_len);
    assign w_remote_end = pbts_pkg::t_len'(o_chunk.chunk_remote_addr[pbts_pkg::PAGE_BITS-1:0])
                        + pbts_pkg::t_len'(o_chunk.chunk_len);
    assign w_in_page    = (w_local_end <= pbts_pkg::t_len'(pbts_pkg::PAGE_BYTES))
                       && (w_remote_end <= pbts_pkg::t_len'(pbts_pkg::PAGE_BYTES));

    // Shape of a rejected chunk and of a normal chunk.
    assign w_reject_ok  = o_chunk.last_chunk && (o_chunk.chunk_len == '0);
    assign w_chunk_ok   = (o_chunk.chunk_len != '0) && w_in_page;

    // Reset leaves no chunk waiting.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, o_empty)

    // A waiting chunk that is not taken stays and holds its value.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_chunk))

    // A rejected request gives one closing chunk of zero length.
    `ASSERT_SAME(a_reject, i_clk, i_rst_n, !o_empty && o_chunk.too_long, w_reject_ok)

    // A normal chunk is not empty and stays inside one page on both sides.
    `ASSERT_SAME(a_in_page, i_clk, i_rst_n, !o_empty && !o_chunk.too_long, w_chunk_ok)

endmodule

bind page_boundary_transfer_splitter_top pbts_checker u_pbts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_chunk (o_chunk)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the transfer splitter: random bursts in, random stalls out.
`timescale 1ns / 1ps

module tb_top;
    import pbts_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int          RANDOM_REQS = 450;
    localparam int          TAIL_CYCLES = 40;
    localparam int          PRINT_CAP   = 100;

    // Receiver behavior, changed at random intervals.
    typedef enum logic [1:0] {
        POP_STEADY,
        POP_COIN,
        POP_HOLD
    } t_pop_mode;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_push;
    logic   o_full;
    t_req   i_req;
    logic   o_empty;
    logic   i_pop;
    t_chunk o_chunk;

    t_req        pending_reqs[$];
    t_chunk      pending_chunks[$];
    int unsigned num_fails   = 0;
    int unsigned chunks_seen = 0;
    int unsigned cycle_count = 0;
    bit          req_taken   = 1'b0;
    bit          draining    = 1'b0;
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned pop_left    = 0;
    t_pop_mode   pop_mode    = POP_STEADY;
    logic        pop_now;

    page_boundary_transfer_splitter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_req   (i_req),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_chunk (o_chunk)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Bytes from an address to the end of its page.
    function automatic int unsigned bytes_to_page_end(input t_addr addr);
        return unsigned'(PAGE_BYTES) - (addr % unsigned'(PAGE_BYTES));
    endfunction

    function automatic void queue_chunk(input t_addr la, input t_addr ra,
                                        input int unsigned len, input logic dir,
                                        input logic last, input logic err);
        t_chunk c;
        c.chunk_local_addr  = la;
        c.chunk_remote_addr = ra;
        c.chunk_len         = t_clen'(len);
        c.chunk_dir         = dir;
        c.last_chunk        = last;
        c.too_long          = err;
        pending_chunks = {pending_chunks, c};
    endfunction

    // Cuts one request at the page boundaries of both sides.
    function automatic void split_request(input t_req r);
        t_addr       la;
        t_addr       ra;
        int unsigned left;
        int unsigned piece;
        int unsigned first;
        int unsigned second;
        la   = r.local_addr;
        ra   = r.remote_addr;
        left = r.length;
        if (left == 0) begin
            return;
        end
        if (left > unsigned'(MAX_LENGTH)) begin
            queue_chunk(la, ra, 0, r.direction, 1'b1, 1'b1);
            return;
        end
        while (left != 0) begin
            piece = bytes_to_page_end(la);
            if (piece > left) begin
                piece = left;
            end
            first = bytes_to_page_end(ra);
            if (first > piece) begin
                first = piece;
            end
            second = piece - first;
            queue_chunk(la, ra, first, r.direction, (second == 0) && (left == piece), 1'b0);
            la += first;
            ra += first;
            // A remote boundary inside the local piece splits it in two.
            if (second != 0) begin
                queue_chunk(la, ra, second, r.direction, left == piece, 1'b0);
                la += second;
                ra += second;
            end
            left -= piece;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (num_fails < PRINT_CAP) begin
            $display("Chunk %0d: %s is 0x%0h, should be 0x%0h", chunks_seen, what, got, want);
        end
        num_fails++;
    endtask

    task automatic check_chunk(input t_chunk got);
        t_chunk want;
        if (pending_chunks.size() == 0) begin
            report_mismatch("unexpected chunk, local address", got.chunk_local_addr, '0);
            return;
        end
        want = pending_chunks.pop_front();
        if (got.chunk_local_addr !== want.chunk_local_addr) begin
            report_mismatch("local address", got.chunk_local_addr, want.chunk_local_addr);
        end
        if (got.chunk_remote_addr !== want.chunk_remote_addr) begin
            report_mismatch("remote address", got.chunk_remote_addr, want.chunk_remote_addr);
        end
        if (got.chunk_len !== want.chunk_len) begin
            report_mismatch("length", 32'(got.chunk_len), 32'(want.chunk_len));
        end
        if (got.chunk_dir !== want.chunk_dir) begin
            report_mismatch("direction", 32'(got.chunk_dir), 32'(want.chunk_dir));
        end
        if (got.last_chunk !== want.last_chunk) begin
            report_mismatch("last flag", 32'(got.last_chunk), 32'(want.last_chunk));
        end
        if (got.too_long !== want.too_long) begin
            report_mismatch("too-long flag", 32'(got.too_long), 32'(want.too_long));
        end
    endtask

    function automatic void add_req(input t_addr la, input t_addr ra,
                                    input int unsigned len, input logic dir);
        t_req r;
        r.local_addr  = la;
        r.remote_addr = ra;
        r.length      = t_len'(len);
        r.direction   = dir;
        pending_reqs = {pending_reqs, r};
    endfunction

    // Addresses lean toward page ends, page starts and the top of the space.
    function automatic t_addr random_addr();
        t_addr       a;
        int unsigned pick;
        a    = $urandom;
        pick = $urandom_range(0, 9);
        if (pick >= 5 && pick <= 7) begin
            a = a - (a % unsigned'(PAGE_BYTES)) + unsigned'(PAGE_BYTES)
                - $urandom_range(1, 64);
        end else if (pick == 8) begin
            a = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        end else if (pick == 9) begin
            a = a - (a % unsigned'(PAGE_BYTES));
        end
        return a;
    endfunction

    // Mostly short requests, some long ones, a few empty or too long.
    function automatic int unsigned random_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return 0;
        end else if (pick < 60) begin
            return $urandom_range(1, PAGE_BYTES);
        end else if (pick < 78) begin
            return $urandom_range(PAGE_BYTES + 1, 4 * PAGE_BYTES);
        end else if (pick < 88) begin
            return $urandom_range(4 * PAGE_BYTES + 1, MAX_LENGTH);
        end else if (pick < 92) begin
            return MAX_LENGTH;
        end
        return $urandom_range(MAX_LENGTH + 1, 131071);
    endfunction

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted chunk.
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (i_push && !o_full) begin
                split_request(i_req);
                void'(pending_reqs.pop_front());
                req_taken = 1'b1;
            end
            if (i_pop && !o_empty) begin
                check_chunk(o_chunk);
                chunks_seen++;
            end
        end
    end

    // Driver: requests in bursts with gaps, pops on a pattern of their own.
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_push <= 1'b0;
            i_pop  <= 1'b0;
        end else begin
            if (req_taken && burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 25);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_push <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_push <= 1'b1;
                i_req  <= pending_reqs[0];
            end else begin
                i_push <= 1'b0;
            end

            if (pop_left == 0) begin
                pop_mode = t_pop_mode'($urandom_range(0, 2));
                pop_left = (pop_mode == POP_HOLD) ? $urandom_range(1, 40)
                                                  : $urandom_range(10, 80);
            end
            pop_left--;
            case (pop_mode)
                POP_STEADY: pop_now = 1'b1;
                POP_COIN:   pop_now = 1'($urandom_range(0, 1));
                default:    pop_now = 1'b0;
            endcase
            i_pop <= pop_now | draining;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        i_rst_n = 1'b0;
        i_push  = 1'b0;
        i_pop   = 1'b0;
        i_req   = '0;

        // Directed: empty, single byte, full page, longest, too long, wraps and offsets.
        add_req(32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_req(32'h0000_0000, 32'h0000_0000, 1, 1'b1);
        add_req(32'h0000_1000, 32'h0000_2000, PAGE_BYTES, 1'b0);
        add_req(32'h0000_0000, 32'h0000_0000, MAX_LENGTH, 1'b1);
        add_req(32'h0000_0001, 32'h0000_0801, MAX_LENGTH, 1'b0);
        add_req(32'h0000_0800, 32'h0000_0801, MAX_LENGTH, 1'b1);
        add_req(32'h0000_0FFF, 32'h0000_0800, MAX_LENGTH, 1'b1);
        add_req(32'h1234_5678, 32'h9ABC_DEF0, MAX_LENGTH + 1, 1'b0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 131071, 1'b1);
        add_req(32'h5555_5555, 32'hAAAA_AAAA, 17'h15555, 1'b1);
        add_req(32'hAAAA_AAAA, 32'h5555_5555, 17'h0AAAA, 1'b0);
        add_req(32'hFFFF_FFF0, 32'h0000_0100, 64, 1'b0);
        add_req(32'h0000_0100, 32'hFFFF_FFF8, 64, 1'b1);
        add_req(32'hFFFF_FF00, 32'hFFFF_F800, 2 * PAGE_BYTES, 1'b0);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1);
        add_req(32'h0000_0FFF, 32'h0000_0FFF, 2, 1'b0);
        add_req(32'h0000_0800, 32'h0000_0000, PAGE_BYTES, 1'b1);
        add_req(32'h0000_0000, 32'h0000_0800, PAGE_BYTES, 1'b0);
        add_req(32'h0000_0001, 32'h0000_0002, MAX_LENGTH - 1, 1'b1);
        add_req(32'h7FFF_F000, 32'h8000_0000, PAGE_BYTES + 1, 1'b0);

        // Random: remote offset sometimes matches the local one.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            t_addr la;
            t_addr ra;
            la = random_addr();
            ra = random_addr();
            if ($urandom_range(0, 4) == 0) begin
                ra = ra - (ra % unsigned'(PAGE_BYTES)) + (la % unsigned'(PAGE_BYTES));
            end
            add_req(la, ra, random_len(), 1'($urandom_range(0, 1)));
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0) @(posedge i_clk);
        while (pending_chunks.size() != 0) @(posedge i_clk);
        // Keep popping a while so that a stray chunk still gets caught.
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (num_fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
